// ===== hdl/k_subset_enumerator_assert.svh =====
// Assertion macros for the k-subset enumerator.
`ifndef K_SUBSET_ENUMERATOR_ASSERT_SVH
`define K_SUBSET_ENUMERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define KSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kse assertion failed");
`define KSE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("kse assertion failed");
`else
`define KSE_ASSERT(lbl, prop)
`define KSE_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== hdl/kse_pkg.sv =====
// Shared types and constants for the k-subset enumerator.
package kse_pkg;

  localparam int CFG_W  = 8;
  localparam int SET_W  = 5;
  localparam int SUB_W  = 4;
  localparam int ELEM_W = 4;
  localparam int IDX_W  = 4;
  localparam int DATA_W = 8;

  localparam logic [IDX_W-1:0] REG_SET_SIZE    = 4'd0;
  localparam logic [IDX_W-1:0] REG_SUBSET_SIZE = 4'd1;

  localparam logic [SET_W-1:0] SET_SIZE_RST    = 5'd5;
  localparam logic [SUB_W-1:0] SUBSET_SIZE_RST = 4'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_ADV  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [CFG_W-1:0] nk;
    logic [CFG_W-1:0] k;
  } kse_ctl_t;

endpackage

// ===== hdl/kse_if.sv =====
// Handshake interfaces: request, result word and configuration write channels.
interface kse_in_if import kse_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface kse_out_if import kse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              last_in_subset;
  logic              exhausted;
  modport source (output valid, output element, output last_in_subset, output exhausted,
                  input ready);
  modport sink   (input valid, input element, input last_in_subset, input exhausted,
                  output ready);
endinterface

interface kse_cfg_if import kse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/kse_cell.sv =====
// One position cell: holds a chosen position, advances, fills and rotates.
module kse_cell import kse_pkg::*; #(
  parameter int PW  = 4,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  kse_ctl_t      ctl,
  input  logic [PW-1:0] wrap_p,
  input  logic [PW-1:0] right_p,
  input  logic          right_adv,
  input  logic          tail_in,
  input  logic [PW-1:0] fill_in,
  output logic [PW-1:0] p,
  output logic          can_adv,
  output logic          tail_out,
  output logic [PW-1:0] fill_out
);

  logic [PW-1:0] p_r, p_nxt;
  logic [PW-1:0] inc_v;
  logic          active, is_j, last_cell;

  assign active    = CFG_W'(IDX) < ctl.k;
  assign last_cell = CFG_W'(IDX + 1) == ctl.k;
  // position may still grow while below n - k + index
  assign can_adv   = active &&
                     ((CFG_W+1)'(p_r) < ((CFG_W+1)'(ctl.nk) + (CFG_W+1)'(IDX)));
  assign is_j      = can_adv && !right_adv;
  assign inc_v     = (is_j ? p_r : fill_in) + 1'b1;
  assign tail_out  = is_j || tail_in;
  assign fill_out  = inc_v;
  assign p         = p_r;

  always_comb begin
    unique case (ctl.op)
      OP_HOLD: p_nxt = p_r;
      OP_INIT: p_nxt = PW'(IDX);
      OP_ADV:  p_nxt = tail_out ? inc_v : p_r;
      OP_ROT:  p_nxt = last_cell ? wrap_p : right_p;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== hdl/k_subset_enumerator.sv =====
// Top level: lexicographic k-subset enumerator over a row of position cells.
//
//  channel  dir  word                                   accepted when
//  in_ch    in   restart                                valid && ready
//  out_ch   out  element, last_in_subset, exhausted     valid && ready
//  cfg_ch   in   index, data                            valid && ready (always ready)
//
// One request first updates the cell row, then shifts the k words of the subset
// out through cell 0; an exhausted request gives a single word.
// The row rotates one cell per word.
// Reset (rst_n low, synchronous) gives n = 5, k = 3 and a fresh enumeration.
// A stalled output holds its word; the row waits until the word is taken.
`include "k_subset_enumerator_assert.svh"

module k_subset_enumerator import kse_pkg::*; #(
  parameter int MAX_VALUES = 16,
  parameter int MAX_SUBSET = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  kse_in_if.sink     in_ch,
  kse_out_if.source  out_ch,
  kse_cfg_if.sink    cfg_ch
);

  localparam int PW    = $clog2(MAX_VALUES);
  localparam int CNT_W = $clog2(MAX_SUBSET + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_EXH  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SET_W-1:0]  set_size_r;
  logic [SUB_W-1:0]  subset_size_r;
  logic              started_r, started_nxt;
  logic              finished_r, finished_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_elem_r;
  logic              out_last_r, out_exh_r;
  logic              load_word, load_exh;

  logic [CFG_W-1:0]  n_c, k_c;
  logic              accept, st_c, fin_c, bad_c, any_adv, out_load, last_emit;
  logic              cfg_wr, cfg_clr;
  logic [1:0]        op_c;
  kse_ctl_t          ctl;

  logic [PW-1:0]     p_c    [MAX_SUBSET+1];
  logic [PW-1:0]     fill_c [MAX_SUBSET+1];
  logic [MAX_SUBSET:0] adv_c;
  logic [MAX_SUBSET:0] tail_c;

  assign n_c = (CFG_W'(set_size_r) > CFG_W'(MAX_VALUES)) ? CFG_W'(MAX_VALUES)
                                                         : CFG_W'(set_size_r);
  assign k_c = CFG_W'(subset_size_r);

  assign in_ch.ready  = state_r == ST_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_clr      = cfg_wr && ((cfg_ch.index == REG_SET_SIZE) ||
                                   (cfg_ch.index == REG_SUBSET_SIZE));

  assign st_c    = started_r && !in_ch.restart;
  assign fin_c   = finished_r && !in_ch.restart;
  assign bad_c   = (k_c == '0) || (k_c > CFG_W'(MAX_SUBSET)) || (k_c > n_c) || fin_c;
  assign any_adv = |adv_c[MAX_SUBSET-1:0];

  assign out_load  = !out_valid_r || out_ch.ready;
  assign last_emit = (CFG_W'(cnt_r) + 1'b1) == k_c;

  assign ctl = '{op: op_c, nk: n_c - k_c, k: k_c};

  // cell row
  assign adv_c[MAX_SUBSET]  = 1'b0;
  assign p_c[MAX_SUBSET]    = p_c[0];
  assign tail_c[0]          = 1'b0;
  assign fill_c[0]          = '0;

  for (genvar g = 0; g < MAX_SUBSET; g++) begin : g_cell
    kse_cell #(
      .PW  (PW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wrap_p    (p_c[0]),
      .right_p   (p_c[g+1]),
      .right_adv (adv_c[g+1]),
      .tail_in   (tail_c[g]),
      .fill_in   (fill_c[g]),
      .p         (p_c[g]),
      .can_adv   (adv_c[g]),
      .tail_out  (tail_c[g+1]),
      .fill_out  (fill_c[g+1])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    finished_nxt = finished_r;
    cnt_nxt      = cnt_r;
    op_c         = OP_HOLD;
    load_word    = 1'b0;
    load_exh     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          started_nxt  = st_c;
          finished_nxt = fin_c;
          cnt_nxt      = '0;
          if (bad_c) begin
            state_nxt = ST_EXH;
          end else if (!st_c) begin
            op_c        = OP_INIT;
            started_nxt = 1'b1;
            state_nxt   = ST_EMIT;
          end else if (any_adv) begin
            op_c      = OP_ADV;
            state_nxt = ST_EMIT;
          end else begin
            finished_nxt = 1'b1;
            state_nxt    = ST_EXH;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          op_c      = OP_ROT;
          load_word = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (last_emit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EXH: begin
        if (out_load) begin
          load_exh  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a write to the set size or subset size register starts the enumeration over
    if (cfg_clr) begin
      started_nxt  = 1'b0;
      finished_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = (load_word || load_exh) ? 1'b1 :
                         (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      set_size_r    <= SET_SIZE_RST;
      subset_size_r <= SUBSET_SIZE_RST;
      started_r     <= 1'b0;
      finished_r    <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      finished_r  <= finished_nxt;
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          REG_SET_SIZE: begin
            set_size_r <= cfg_ch.data[SET_W-1:0];
          end
          REG_SUBSET_SIZE: begin
            subset_size_r <= cfg_ch.data[SUB_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_word) begin
      out_elem_r <= ELEM_W'(p_c[0]);
      out_last_r <= last_emit;
      out_exh_r  <= 1'b0;
    end else if (load_exh) begin
      out_elem_r <= '0;
      out_last_r <= 1'b1;
      out_exh_r  <= 1'b1;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.element        = out_elem_r;
  assign out_ch.last_in_subset = out_last_r;
  assign out_ch.exhausted      = out_exh_r;

  `KSE_ASSERT(a_emit_started, (state_r != ST_EMIT) || started_r)
  `KSE_ASSERT(a_emit_cnt_in_range, (state_r != ST_EMIT) || (CFG_W'(cnt_r) < k_c))
  `KSE_ASSERT(a_exh_word, !(out_valid_r && out_exh_r) || (out_last_r && out_elem_r == '0))
  `KSE_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE)

endmodule

// ===== tb/kse_checker.sv =====
`timescale 1ns / 100ps
// Checker for the k-subset enumerator: predicts subset words and compares output words.
module kse_checker import kse_pkg::*; #(
  parameter int MAX_VALUES = 16,
  parameter int MAX_SUBSET = 8
) (
  input  logic clk,
  input  logic rst_n,
  kse_in_if    in_ch,
  kse_out_if   out_ch,
  kse_cfg_if   cfg_ch,
  output int   mismatches,
  output int   words_pending
);

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last_in_subset;
    logic              exhausted;
  } subset_word_t;

  subset_word_t      expected_words[$];
  subset_word_t      want;
  logic [SET_W-1:0]  set_size;
  logic [SUB_W-1:0]  subset_size;
  logic [ELEM_W-1:0] picks[MAX_SUBSET];
  bit                started;
  bit                finished;

  function automatic subset_word_t make_word(input logic [ELEM_W-1:0] element,
                                             input logic last, input logic exhausted);
    subset_word_t w;
    w.element        = element;
    w.last_in_subset = last;
    w.exhausted      = exhausted;
    return w;
  endfunction

  // Advance to the next k-combination in lexicographic order and queue its words, or queue the exhausted word.
  function automatic void next_subset(input logic restart);
    int n;
    int k;
    int j;
    bit found;
    n     = set_size;
    k     = subset_size;
    found = 1'b0;
    if (restart) begin
      started  = 1'b0;
      finished = 1'b0;
    end
    if (n > MAX_VALUES) n = MAX_VALUES;
    if (k == 0 || k > MAX_SUBSET || k > n || finished) begin
      expected_words.push_back(make_word('0, 1'b1, 1'b1));
      return;
    end
    if (!started) begin
      for (int i = 0; i < k; i++) picks[i] = ELEM_W'(i);
      started = 1'b1;
    end else begin
      j = k;
      while (j > 0 && !found) begin
        j--;
        if (int'(picks[j]) < n - k + j) found = 1'b1;
      end
      if (!found) begin
        finished = 1'b1;
        expected_words.push_back(make_word('0, 1'b1, 1'b1));
        return;
      end
      picks[j] = picks[j] + 1'b1;
      for (int i = j + 1; i < k; i++) picks[i] = picks[i-1] + 1'b1;
    end
    for (int i = 0; i < k; i++) begin
      expected_words.push_back(make_word(picks[i], i == k - 1, 1'b0));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      set_size    = SET_SIZE_RST;
      subset_size = SUBSET_SIZE_RST;
      started     = 1'b0;
      finished    = 1'b0;
      mismatches  = 0;
      expected_words.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SET_SIZE: begin
            set_size = cfg_ch.data[SET_W-1:0];
            started  = 1'b0;
            finished = 1'b0;
          end
          REG_SUBSET_SIZE: begin
            subset_size = cfg_ch.data[SUB_W-1:0];
            started     = 1'b0;
            finished    = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) next_subset(in_ch.restart);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: element %0d last_in_subset %0d exhausted %0d",
                 out_ch.element, out_ch.last_in_subset, out_ch.exhausted);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_ch.element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, out_ch.element);
            mismatches++;
          end
          if (out_ch.last_in_subset !== want.last_in_subset) begin
            $error("last_in_subset: expected %0d, got %0d",
                   want.last_in_subset, out_ch.last_in_subset);
            mismatches++;
          end
          if (out_ch.exhausted !== want.exhausted) begin
            $error("exhausted: expected %0d, got %0d", want.exhausted, out_ch.exhausted);
            mismatches++;
          end
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the k-subset enumerator: requests, register writes, back-pressure, verdict.
module tb;
  import kse_pkg::*;

  localparam int MAX_VALUES     = 16;
  localparam int MAX_SUBSET     = 8;
  localparam int TOTAL_REQUESTS = 230;
  localparam int HOLD_AT        = 120;
  localparam int LONG_HOLD      = 400;
  localparam int IDLE_LIMIT     = 2000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   words_pending;
  int   requests_sent = 0;
  int   idle_cycles   = 0;
  bit   long_hold_done = 1'b0;

  kse_in_if  in_ch ();
  kse_out_if out_ch ();
  kse_cfg_if cfg_ch ();

  k_subset_enumerator #(
    .MAX_VALUES (MAX_VALUES),
    .MAX_SUBSET (MAX_SUBSET)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  kse_checker #(
    .MAX_VALUES (MAX_VALUES),
    .MAX_SUBSET (MAX_SUBSET)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic run_requests(input int count, input int restart_pct);
    repeat (count) send_request($urandom_range(0, 99) < restart_pct);
  endtask

  // Stop offering and let every outstanding word drain before the next write.
  task automatic end_phase();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [DATA_W-1:0] n_word, input logic [DATA_W-1:0] k_word);
    cfg_write(REG_SET_SIZE, n_word);
    cfg_write(REG_SUBSET_SIZE, k_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // Output back-pressure, with one long hold while requests keep coming.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && requests_sent >= HOLD_AT && in_ch.valid) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n_val;
    int k_val;
    int mode;
    int count;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_SET_SIZE;
    cfg_ch.data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: run past the end, repeat the exhausted word, then start over
    repeat (13) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    end_phase();

    // set size saturates, widest subset
    configure(8'hFF, 8'h08);
    run_requests(2, 0);
    end_phase();

    // zero subset size
    configure(8'h10, 8'h00);
    run_requests(1, 0);
    end_phase();

    // subset size above the maximum
    configure(8'h04, 8'h0F);
    run_requests(1, 0);
    end_phase();

    // subset larger than the set
    configure(8'h02, 8'h03);
    run_requests(1, 0);
    end_phase();

    // single position
    configure(8'h01, 8'h01);
    run_requests(3, 0);
    end_phase();

    // one subset only; an unmapped write must not restart it
    configure(8'h08, 8'h08);
    run_requests(2, 0);
    end_phase();
    cfg_write(IDX_W'($urandom_range(2, 15)), DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    run_requests(1, 0);
    end_phase();

    while (requests_sent < TOTAL_REQUESTS) begin
      mode  = $urandom_range(0, 9);
      count = $urandom_range(4, 30);
      case (mode)
        0: begin
          n_val = $urandom_range(0, 31);
          k_val = $urandom_range(0, 15);
        end
        1: begin
          n_val = 16;
          k_val = 1;
          count = $urandom_range(17, 24);
        end
        2: begin
          n_val = 16;
          k_val = $urandom_range(7, 8);
        end
        default: begin
          n_val = $urandom_range(1, 7);
          k_val = $urandom_range(1, n_val);
        end
      endcase
      if (count > TOTAL_REQUESTS - requests_sent) count = TOTAL_REQUESTS - requests_sent;
      if ($urandom_range(0, 3) == 0) cfg_write(IDX_W'($urandom_range(2, 15)), DATA_W'($urandom));
      if (mode < 3 || $urandom_range(0, 4) != 0)
        cfg_write(REG_SET_SIZE, {3'($urandom), 5'(n_val)});
      cfg_write(REG_SUBSET_SIZE, {4'($urandom), 4'(k_val)});
      cfg_ch.valid <= 1'b0;
      run_requests(count, 8);
      end_phase();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
